// ----- src/median_filter_2d_zero_pad_core_assert.svh -----
// Assertion macros used by the median filter back end.
`ifndef MEDIAN_FILTER_2D_ZERO_PAD_CORE_ASSERT_SVH
`define MEDIAN_FILTER_2D_ZERO_PAD_CORE_ASSERT_SVH

// Same-cycle implication.
`define MFZP_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MFZP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/mfzp_pkg.sv -----
`timescale 1ns / 1ps

package mfzp_pkg;

   // Geometry limits
   localparam int MAX_WINDOW = 7;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_ROWS   = 1024;
   localparam int PIXEL_BITS = 16;

   localparam int WIN_DEPTH   = MAX_WINDOW * MAX_WINDOW;
   localparam int LINES       = MAX_WINDOW - 1;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int CY_BITS     = $clog2(MAX_ROWS);
   localparam int WIDTH_BITS  = $clog2(MAX_WIDTH + 1);
   localparam int HEIGHT_BITS = $clog2(MAX_ROWS + 1);
   localparam int HALF_BITS   = $clog2(MAX_WINDOW / 2 + 1);
   localparam int RANK_BITS   = $clog2(WIN_DEPTH);
   localparam int TOTAL_BITS  = $clog2(MAX_WIDTH * MAX_ROWS + 1);
   localparam int POS_BITS    =
      $clog2(MAX_WIDTH * MAX_ROWS + (MAX_WINDOW / 2) * (MAX_WIDTH + 1) + 1);

   // Register port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 11;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEIGHT = 2'd2;
   localparam logic [2:0]  RESET_WINDOW = 3'd3;
   localparam logic [10:0] RESET_WIDTH  = 11'd640;
   localparam logic [10:0] RESET_HEIGHT = 11'd512;

   // Queues
   localparam int MIDQ_DEPTH = 4;
   localparam int MIDQ_BITS  = $clog2(MIDQ_DEPTH);
   localparam int OUTQ_DEPTH = 32;
   localparam int OUTQ_BITS  = $clog2(OUTQ_DEPTH);

   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef logic [MAX_WINDOW-1:0][PIXEL_BITS-1:0] col_type;
   typedef logic [WIN_DEPTH-1:0][PIXEL_BITS-1:0] win_type;

   typedef struct packed {
      logic        operation;
      logic [15:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [15:0] pixel_out;
      logic        frame_end;
   } rsp_type;

   typedef struct packed {
      logic [WIDTH_BITS-1:0]  width;
      logic [HEIGHT_BITS-1:0] height;
      logic [HALF_BITS-1:0]   half;
      logic [RANK_BITS-1:0]   rank;
   } cfg_type;

   typedef struct packed {
      logic [COL_BITS-1:0] col;
      pixel_type           pixel;
      logic                emit;
      logic                last;
      logic [COL_BITS-1:0] cx;
      logic [CY_BITS-1:0]  cy;
   } item_type;

   // Odd window size, returned as its half width
   function automatic logic [HALF_BITS-1:0] eff_half(input logic [2:0] ws);
      logic [4:0] w;
      w = {2'b00, ws};
      if (w > 5'(MAX_WINDOW)) w = 5'(MAX_WINDOW);
      if (!w[0]) w = (w == 5'd0) ? 5'd1 : w - 5'd1;
      return HALF_BITS'(w >> 1);
   endfunction

   function automatic logic [WIDTH_BITS-1:0] eff_width(input logic [10:0] v);
      logic [WIDTH_BITS-1:0] r;
      if (v == 11'd0) r = WIDTH_BITS'(1);
      else if (int'(v) > MAX_WIDTH) r = WIDTH_BITS'(MAX_WIDTH);
      else r = WIDTH_BITS'(v);
      return r;
   endfunction

   function automatic logic [HEIGHT_BITS-1:0] eff_height(input logic [10:0] v);
      logic [HEIGHT_BITS-1:0] r;
      if (v == 11'd0) r = HEIGHT_BITS'(1);
      else if (int'(v) > MAX_ROWS) r = HEIGHT_BITS'(MAX_ROWS);
      else r = HEIGHT_BITS'(v);
      return r;
   endfunction

   // Rank of the median among WIN_DEPTH slots when the unused ones hold zero
   function automatic logic [RANK_BITS-1:0] median_rank(input logic [HALF_BITS-1:0] h);
      int w;
      w = 2 * int'(h) + 1;
      return RANK_BITS'(WIN_DEPTH - ((w * w + 1) >> 1));
   endfunction

endpackage

// ----- src/mfzp_ram.sv -----
`timescale 1ns / 1ps

module mfzp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and read old data with a registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/mfzp_front.sv -----
`timescale 1ns / 1ps

module mfzp_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [mfzp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mfzp_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                                req_push,
   input  mfzp_pkg::req_type                   req_data,
   input  logic                                q_full,
   output logic                                q_push,
   output mfzp_pkg::item_type                  q_item,
   output mfzp_pkg::cfg_type                   cfg
);

   logic [2:0]                        window_ff;
   logic [10:0]                       width_ff;
   logic [10:0]                       height_ff;
   logic [mfzp_pkg::COL_BITS-1:0]     col_ff, col_in;
   logic [mfzp_pkg::POS_BITS-1:0]     pos_ff, pos_in;
   logic [mfzp_pkg::COL_BITS-1:0]     ox_ff, ox_in;
   logic [mfzp_pkg::CY_BITS-1:0]      oy_ff, oy_in;

   logic [mfzp_pkg::TOTAL_BITS-1:0]   total;
   logic [mfzp_pkg::POS_BITS-1:0]     lag;
   logic                              accept, in_frame, take, emit, last, csr_hit;

   // Effective configuration
   always_comb begin
      cfg.width  = mfzp_pkg::eff_width(width_ff);
      cfg.height = mfzp_pkg::eff_height(height_ff);
      cfg.half   = mfzp_pkg::eff_half(window_ff);
      cfg.rank   = mfzp_pkg::median_rank(cfg.half);
   end

   assign total = mfzp_pkg::TOTAL_BITS'(cfg.width * cfg.height);
   assign lag   = mfzp_pkg::POS_BITS'(cfg.half * cfg.width)
                + mfzp_pkg::POS_BITS'(cfg.half);

   // Classify the incoming word
   assign accept   = req_push && !q_full;
   assign in_frame = mfzp_pkg::POS_BITS'(pos_ff) < mfzp_pkg::POS_BITS'(total);
   assign take     = accept && !(req_data.operation && in_frame);
   assign emit     = pos_ff >= lag;
   assign last     = emit
                   && (mfzp_pkg::WIDTH_BITS'(ox_ff) == cfg.width - mfzp_pkg::WIDTH_BITS'(1))
                   && (mfzp_pkg::HEIGHT_BITS'(oy_ff) == cfg.height - mfzp_pkg::HEIGHT_BITS'(1));
   assign csr_hit  = csr_wr_en && (csr_index == mfzp_pkg::CSR_WINDOW
                   || csr_index == mfzp_pkg::CSR_WIDTH || csr_index == mfzp_pkg::CSR_HEIGHT);

   assign q_push        = take;
   assign q_item.col    = col_ff;
   assign q_item.pixel  = mfzp_pkg::PIXEL_BITS'(req_data.pixel_in);
   assign q_item.emit   = emit;
   assign q_item.last   = last;
   assign q_item.cx     = ox_ff;
   assign q_item.cy     = oy_ff;

   // Advance stream and result positions
   always_comb begin
      col_in = col_ff;
      pos_in = pos_ff;
      ox_in  = ox_ff;
      oy_in  = oy_ff;
      priority if (csr_hit || (take && last)) begin
         col_in = '0;
         pos_in = '0;
         ox_in  = '0;
         oy_in  = '0;
      end else if (take) begin
         pos_in = pos_ff + mfzp_pkg::POS_BITS'(1);
         if (mfzp_pkg::WIDTH_BITS'(col_ff) + mfzp_pkg::WIDTH_BITS'(1) >= cfg.width) begin
            col_in = '0;
         end else begin
            col_in = col_ff + mfzp_pkg::COL_BITS'(1);
         end
         if (emit) begin
            if (mfzp_pkg::WIDTH_BITS'(ox_ff) + mfzp_pkg::WIDTH_BITS'(1) >= cfg.width) begin
               ox_in = '0;
               oy_in = oy_ff + mfzp_pkg::CY_BITS'(1);
            end else begin
               ox_in = ox_ff + mfzp_pkg::COL_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= mfzp_pkg::RESET_WINDOW;
         width_ff  <= mfzp_pkg::RESET_WIDTH;
         height_ff <= mfzp_pkg::RESET_HEIGHT;
         col_ff    <= '0;
         pos_ff    <= '0;
         ox_ff     <= '0;
         oy_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               mfzp_pkg::CSR_WINDOW: window_ff <= csr_wdata[2:0];
               mfzp_pkg::CSR_WIDTH:  width_ff  <= csr_wdata[10:0];
               mfzp_pkg::CSR_HEIGHT: height_ff <= csr_wdata[10:0];
               default: ;
            endcase
         end
         col_ff <= col_in;
         pos_ff <= pos_in;
         ox_ff  <= ox_in;
         oy_ff  <= oy_in;
      end
   end

endmodule

// ----- src/mfzp_median.sv -----
`timescale 1ns / 1ps

module mfzp_median (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  mfzp_pkg::win_type              in_vals,
   input  logic [mfzp_pkg::RANK_BITS-1:0] in_rank,
   input  logic                           in_last,
   output logic                           out_valid,
   output mfzp_pkg::pixel_type            out_pixel,
   output logic                           out_last
);

   localparam int STAGES = mfzp_pkg::PIXEL_BITS;

   logic                              valid_ff [STAGES+1];
   logic                              last_ff  [STAGES+1];
   mfzp_pkg::win_type                 vals_ff  [STAGES+1];
   logic [mfzp_pkg::WIN_DEPTH-1:0]    cand_ff  [STAGES+1];
   logic [mfzp_pkg::RANK_BITS-1:0]    rank_ff  [STAGES+1];
   mfzp_pkg::pixel_type               res_ff   [STAGES+1];

   // Capture the window
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      last_ff[0] <= in_last;
      vals_ff[0] <= in_vals;
      cand_ff[0] <= '1;
      rank_ff[0] <= in_rank;
      res_ff[0]  <= '0;
   end

   // Decide one result bit per stage, most significant first
   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam int B = STAGES - 1 - s;
      logic [mfzp_pkg::WIN_DEPTH-1:0] bits, zeros;
      logic [mfzp_pkg::RANK_BITS:0]   cnt0;
      logic                           pick_one;
      mfzp_pkg::pixel_type            res_in;

      always_comb begin
         for (int i = 0; i < mfzp_pkg::WIN_DEPTH; i++) begin
            bits[i] = vals_ff[s][i][B];
         end
         zeros    = cand_ff[s] & ~bits;
         cnt0     = (mfzp_pkg::RANK_BITS+1)'($countones(zeros));
         pick_one = {1'b0, rank_ff[s]} >= cnt0;
         res_in    = res_ff[s];
         res_in[B] = pick_one;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else begin
            valid_ff[s+1] <= valid_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         last_ff[s+1] <= last_ff[s];
         vals_ff[s+1] <= vals_ff[s];
         res_ff[s+1]  <= res_in;
         if (pick_one) begin
            cand_ff[s+1] <= cand_ff[s] & bits;
            rank_ff[s+1] <= mfzp_pkg::RANK_BITS'({1'b0, rank_ff[s]} - cnt0);
         end else begin
            cand_ff[s+1] <= zeros;
            rank_ff[s+1] <= rank_ff[s];
         end
      end
   end

   assign out_valid = valid_ff[STAGES];
   assign out_pixel = res_ff[STAGES];
   assign out_last  = last_ff[STAGES];

endmodule

// ----- src/mfzp_back.sv -----
`timescale 1ns / 1ps
`include "median_filter_2d_zero_pad_core_assert.svh"

module mfzp_back (
   input  logic               clock,
   input  logic               reset,
   input  mfzp_pkg::cfg_type  cfg,
   input  logic               q_valid,
   input  mfzp_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output mfzp_pkg::rsp_type  rsp_data
);

   localparam int MW = mfzp_pkg::MAX_WINDOW;

   logic                          pop_go;
   logic [mfzp_pkg::OUTQ_BITS:0]  used_ff;

   logic                          s1_valid_ff, s1_fwd_ff;
   mfzp_pkg::item_type            s1_item_ff;
   mfzp_pkg::pixel_type           rd_data [mfzp_pkg::LINES];
   mfzp_pkg::col_type             col_vec, last_vec_ff;
   mfzp_pkg::col_type             win_ff [MW];
   logic [MW-1:0]                 col_ok_in, row_ok_in, col_ok_ff, row_ok_ff;

   logic                          s2_valid_ff, s2_last_ff;
   mfzp_pkg::win_type             vals;

   logic                          med_valid, med_last;
   mfzp_pkg::pixel_type           med_pixel;

   mfzp_pkg::rsp_type             outq_ff [mfzp_pkg::OUTQ_DEPTH];
   logic [mfzp_pkg::OUTQ_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [mfzp_pkg::OUTQ_BITS:0]  outq_cnt_ff;
   logic                          deq;

   // Take a word only when its result has a reserved slot
   assign pop_go = q_valid && (!q_item.emit
                || used_ff < (mfzp_pkg::OUTQ_BITS+1)'(mfzp_pkg::OUTQ_DEPTH));
   assign q_pop  = pop_go;
   assign deq    = rsp_pop && !rsp_empty;

   // Line stores: one row each, read at pop, rewritten in the next cycle
   for (genvar k = 0; k < mfzp_pkg::LINES; k++) begin : g_line
      mfzp_ram #(
         .WIDTH(mfzp_pkg::PIXEL_BITS),
         .DEPTH(mfzp_pkg::MAX_WIDTH)
      ) u_line (
         .clock   (clock),
         .wr_en   (s1_valid_ff),
         .wr_addr (s1_item_ff.col),
         .wr_data (col_vec[k]),
         .rd_addr (q_item.col),
         .rd_data (rd_data[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_fwd_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= pop_go;
         s1_fwd_ff   <= s1_valid_ff && (s1_item_ff.col == q_item.col);
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= q_item;
   end

   // Build the new column, forwarding the write of the previous word
   always_comb begin
      col_vec[0] = s1_item_ff.pixel;
      for (int k = 1; k < MW; k++) begin
         col_vec[k] = s1_fwd_ff ? last_vec_ff[k-1] : rd_data[k-1];
      end
   end

   // Frame bounds of each window column and row
   always_comb begin
      logic [mfzp_pkg::WIDTH_BITS-1:0]  t, dd;
      logic [mfzp_pkg::HEIGHT_BITS-1:0] u, kk;
      logic [mfzp_pkg::HALF_BITS:0]     two_h;
      two_h = {cfg.half, 1'b0};
      t = mfzp_pkg::WIDTH_BITS'(s1_item_ff.cx) + mfzp_pkg::WIDTH_BITS'(cfg.half);
      u = mfzp_pkg::HEIGHT_BITS'(s1_item_ff.cy) + mfzp_pkg::HEIGHT_BITS'(cfg.half);
      for (int j = 0; j < MW; j++) begin
         dd = mfzp_pkg::WIDTH_BITS'(MW - 1 - j);
         col_ok_in[j] = (dd <= mfzp_pkg::WIDTH_BITS'(two_h)) && (t >= dd)
                      && (t - dd < cfg.width);
      end
      for (int k = 0; k < MW; k++) begin
         kk = mfzp_pkg::HEIGHT_BITS'(k);
         row_ok_in[k] = (kk <= mfzp_pkg::HEIGHT_BITS'(two_h)) && (u >= kk)
                      && (u - kk < cfg.height);
      end
   end

   // Shift the window and hold the column
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         for (int j = 0; j < MW - 1; j++) begin
            win_ff[j] <= win_ff[j+1];
         end
         win_ff[MW-1] <= col_vec;
         last_vec_ff  <= col_vec;
      end
      col_ok_ff  <= col_ok_in;
      row_ok_ff  <= row_ok_in;
      s2_last_ff <= s1_item_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff && s1_item_ff.emit;
      end
   end

   // Zero the slots outside the frame or the window
   always_comb begin
      for (int k = 0; k < MW; k++) begin
         for (int j = 0; j < MW; j++) begin
            vals[k*MW+j] = (col_ok_ff[j] && row_ok_ff[k]) ? win_ff[j][k] : '0;
         end
      end
   end

   mfzp_median u_median (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_vals   (vals),
      .in_rank   (cfg.rank),
      .in_last   (s2_last_ff),
      .out_valid (med_valid),
      .out_pixel (med_pixel),
      .out_last  (med_last)
   );

   // Result queue
   always_ff @(posedge clock) begin
      if (med_valid) begin
         outq_ff[wr_ptr_ff].pixel_out <= 16'(med_pixel);
         outq_ff[wr_ptr_ff].frame_end <= med_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         outq_cnt_ff <= '0;
         used_ff     <= '0;
      end else begin
         if (med_valid) wr_ptr_ff <= wr_ptr_ff + mfzp_pkg::OUTQ_BITS'(1);
         if (deq) rd_ptr_ff <= rd_ptr_ff + mfzp_pkg::OUTQ_BITS'(1);
         outq_cnt_ff <= outq_cnt_ff + (mfzp_pkg::OUTQ_BITS+1)'(med_valid)
                      - (mfzp_pkg::OUTQ_BITS+1)'(deq);
         used_ff     <= used_ff + (mfzp_pkg::OUTQ_BITS+1)'(pop_go && q_item.emit)
                      - (mfzp_pkg::OUTQ_BITS+1)'(deq);
      end
   end

   assign rsp_empty = (outq_cnt_ff == '0);
   assign rsp_data  = outq_ff[rd_ptr_ff];

   `MFZP_ASSERT_IMP(a_outq_room, clock, reset, med_valid, outq_cnt_ff < (mfzp_pkg::OUTQ_BITS+1)'(mfzp_pkg::OUTQ_DEPTH), "result queue overflow")
   `MFZP_ASSERT_IMP(a_reserve_cover, clock, reset, 1'b1, used_ff >= outq_cnt_ff, "reservations below queue fill")
   `MFZP_ASSERT_NEXT(a_emit_flow, clock, reset, s1_valid_ff && s1_item_ff.emit, s2_valid_ff, "emitting word lost before median")

endmodule

// ----- src/median_filter_2d_zero_pad_core.sv -----
`timescale 1ns / 1ps
// Streaming 2-D median filter with zero padding. Pixels enter in raster
// order at up to one word per clock; one result word leaves per clock once
// the window is primed and while the host pops, sustained by six
// single-row line-store RAMs that are read and rewritten once per pixel and
// by a 16-stage bitwise median select. Each result lags its centre pixel by
// half a window of rows and columns, so after the last pixel of a frame the
// host pushes drain words until the word marked frame_end is out. The 32-word
// result queue absorbs stalls on the result side, and a 4-word queue
// decouples intake from processing. Register writes restart the frame; the
// user must make them only while the block is idle, which is not enforced.

module median_filter_2d_zero_pad_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  mfzp_pkg::req_type                   req_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output mfzp_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [mfzp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mfzp_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   mfzp_pkg::cfg_type               cfg;
   logic                            q_push, q_pop, q_valid;
   mfzp_pkg::item_type              q_in_item, q_head;
   mfzp_pkg::item_type              midq_ff [mfzp_pkg::MIDQ_DEPTH];
   logic [mfzp_pkg::MIDQ_BITS-1:0]  mq_wr_ff, mq_rd_ff;
   logic [mfzp_pkg::MIDQ_BITS:0]    mq_cnt_ff;

   mfzp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_data  (req_data),
      .q_full    (req_full),
      .q_push    (q_push),
      .q_item    (q_in_item),
      .cfg       (cfg)
   );

   // Queue between intake and processing
   assign req_full = (mq_cnt_ff == (mfzp_pkg::MIDQ_BITS+1)'(mfzp_pkg::MIDQ_DEPTH));
   assign q_valid  = (mq_cnt_ff != '0);
   assign q_head   = midq_ff[mq_rd_ff];

   always_ff @(posedge clock) begin
      if (q_push) begin
         midq_ff[mq_wr_ff] <= q_in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mq_wr_ff  <= '0;
         mq_rd_ff  <= '0;
         mq_cnt_ff <= '0;
      end else begin
         if (q_push) mq_wr_ff <= mq_wr_ff + mfzp_pkg::MIDQ_BITS'(1);
         if (q_pop) mq_rd_ff <= mq_rd_ff + mfzp_pkg::MIDQ_BITS'(1);
         mq_cnt_ff <= mq_cnt_ff + (mfzp_pkg::MIDQ_BITS+1)'(q_push)
                    - (mfzp_pkg::MIDQ_BITS+1)'(q_pop);
      end
   end

   mfzp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_item    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
